[design/assert_macros.svh]
// Assertion macros shared by the timer table RTL.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/ostt_pkg.sv]
// Shared types and constants of the one-shot timer table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ostt_pkg;

  localparam int unsigned REQ_W       = 3;
  localparam int unsigned IN_ID_W     = 16;
  localparam int unsigned IN_CNT_W    = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned OUT_ID_W    = 16;
  localparam int unsigned REMOVED_W   = 5;
  localparam int unsigned MAX_REPORTS = 16;
  localparam int unsigned REP_W       = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_STOP   = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_TICK   = 3'd3,
    REQ_RESET  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADCOUNT = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_EXPIRED  = 3'd4,
    ST_NOTHING  = 3'd5
  } status_e;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_ID_W-1:0]  expired_id;
    logic [REMOVED_W-1:0] removed_count;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic match;
    logic expire;
  } alu_flags_t;

endpackage

[design/ostt_alu.sv]
// Shared compare/decrement unit of the timer table sequencer.
// Depends on ostt_pkg for the flag struct.
`timescale 1ns / 1ps

module ostt_alu #(
  parameter int unsigned ID_BITS    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic [ID_BITS-1:0]    key_i,
  input  logic [ID_BITS-1:0]    id_i,
  input  logic [COUNT_BITS-1:0] count_i,
  output logic [COUNT_BITS-1:0] dec_o,
  output ostt_pkg::alu_flags_t  flags_o
);

  assign dec_o          = count_i - COUNT_BITS'(1);
  assign flags_o.match  = (id_i == key_i);
  assign flags_o.expire = (dec_o == '0);

endmodule

[design/ostt_out_buf.sv]
// Output register that holds one result beat until the sink takes it.
// Depends on ostt_pkg for the result item struct.
`timescale 1ns / 1ps

module ostt_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ostt_pkg::out_item_t item_i,
  input  logic                ready_i,
  output logic                free_o,
  output logic                valid_o,
  output ostt_pkg::out_item_t item_o
);

  logic                valid_q, valid_d;
  ostt_pkg::out_item_t item_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = push_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[design/one_shot_timer_table.sv]
// One-shot timer table: a sequencer walks a slot memory through one shared ALU.
// Add, reset and undefined requests need no walk; stop, remove and tick walk the slots,
// and a visit keeps or drops one slot. One request at a time: the next request beat is
// taken only once the sequencer is back in idle, which a stalled result port delays.
// Reset (rst_ni low, async) empties the table; slot contents stay undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module one_shot_timer_table #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ostt_pkg::REQ_W-1:0]         req_type_i,
  input  logic [ostt_pkg::IN_ID_W-1:0]       timer_id_i,
  input  logic [ostt_pkg::IN_CNT_W-1:0]      tick_count_i,
  input  logic                               has_handler_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ostt_pkg::STATUS_W-1:0]      status_o,
  output logic [ostt_pkg::OUT_ID_W-1:0]      expired_id_o,
  output logic [ostt_pkg::REMOVED_W-1:0]     removed_count_o,
  output logic                               last_o
);

  // Counter width holds 0..SLOTS; index width addresses the slot memory.
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic                  notify;
    logic [COUNT_BITS-1:0] count;
    logic [ID_BITS-1:0]    id;
  } entry_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_START  = 5'b00010,
    ST_READ   = 5'b00100,
    ST_EXEC   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Latched request.
  logic [ostt_pkg::REQ_W-1:0] req_q;
  logic [ID_BITS-1:0]         key_q;
  logic [COUNT_BITS-1:0]      cnt_q;
  logic                       notify_q;

  // Walk control.
  logic [CNT_W-1:0]          i_q, i_d;
  logic [CNT_W-1:0]          used_q, used_d;
  logic [CNT_W-1:0]          removed_q, removed_d;
  logic [ostt_pkg::REP_W-1:0] rep_q, rep_d;
  logic                      pend_valid_q, pend_valid_d;
  logic [ID_BITS-1:0]        pend_id_q, pend_id_d;

  // Slot memory: one write port, two registered read ports (current slot, tail).
  entry_t           mem_q [SLOTS];
  entry_t           rd_cur_q, rd_tail_q;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [CNT_W-1:0] tail;
  logic             rd_en;

  // Shared unit outputs.
  logic [COUNT_BITS-1:0] dec;
  ostt_pkg::alu_flags_t  flags;

  // Output side.
  logic                push;
  logic                out_free;
  ostt_pkg::out_item_t push_item;
  ostt_pkg::out_item_t out_item;
  logic [31:0]         pend_id_wide;
  logic                report;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign tail         = used_q - CNT_W'(1);
  assign rd_en        = (state_q == ST_READ) && (i_q < used_q);
  assign pend_id_wide = 32'(pend_id_q);
  assign report       = rd_cur_q.notify && (rep_q < ostt_pkg::REP_W'(ostt_pkg::MAX_REPORTS));

  ostt_alu #(
    .ID_BITS   (ID_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_alu (
    .key_i  (key_q),
    .id_i   (rd_cur_q.id),
    .count_i(rd_cur_q.count),
    .dec_o  (dec),
    .flags_o(flags)
  );

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    used_d       = used_q;
    removed_d    = removed_q;
    rep_d        = rep_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    we           = 1'b0;
    waddr        = i_q[IDX_W-1:0];
    wdata        = rd_tail_q;
    push         = 1'b0;
    push_item    = '{status:        ostt_pkg::ST_NOTHING,
                     expired_id:    '0,
                     removed_count: '0,
                     last:          1'b1};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          i_d          = '0;
          removed_d    = '0;
          rep_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = ST_START;
        end
      end
      ST_START: begin
        case (req_q)
          ostt_pkg::REQ_ADD: begin
            // Bad count wins over full; add writes the new entry at the tail.
            if (out_free) begin
              push = 1'b1;
              if (cnt_q == '0) begin
                push_item.status = ostt_pkg::ST_BADCOUNT;
              end else if (used_q == CNT_W'(SLOTS)) begin
                push_item.status = ostt_pkg::ST_FULL;
              end else begin
                push_item.status = ostt_pkg::ST_ADDED;
                we     = 1'b1;
                waddr  = used_q[IDX_W-1:0];
                wdata  = '{notify: notify_q, count: cnt_q, id: key_q};
                used_d = used_q + CNT_W'(1);
              end
              state_d = ST_IDLE;
            end
          end
          ostt_pkg::REQ_STOP, ostt_pkg::REQ_REMOVE, ostt_pkg::REQ_TICK: begin
            state_d = ST_READ;
          end
          ostt_pkg::REQ_RESET: begin
            removed_d = used_q;
            used_d    = '0;
            state_d   = ST_FINISH;
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_READ: begin
        // Fetch current slot and tail; stop the walk past the last entry.
        state_d = (i_q < used_q) ? ST_EXEC : ST_FINISH;
      end
      ST_EXEC: begin
        case (req_q)
          ostt_pkg::REQ_TICK: begin
            if (flags.expire) begin
              // Hold while a reported expiry must flush the pending beat.
              if (!(report && pend_valid_q && !out_free)) begin
                if (report) begin
                  if (pend_valid_q) begin
                    push                 = 1'b1;
                    push_item.status     = ostt_pkg::ST_EXPIRED;
                    push_item.expired_id = pend_id_wide[ostt_pkg::OUT_ID_W-1:0];
                    push_item.last       = 1'b0;
                  end
                  pend_valid_d = 1'b1;
                  pend_id_d    = rd_cur_q.id;
                  rep_d        = rep_q + ostt_pkg::REP_W'(1);
                end
                // Drop the slot: tail moves in and is visited next.
                we      = 1'b1;
                used_d  = tail;
                state_d = ST_READ;
              end
            end else begin
              we      = 1'b1;
              wdata   = '{notify: rd_cur_q.notify, count: dec, id: rd_cur_q.id};
              i_d     = i_q + CNT_W'(1);
              state_d = ST_READ;
            end
          end
          ostt_pkg::REQ_STOP: begin
            if (flags.match) begin
              we        = 1'b1;
              used_d    = tail;
              removed_d = removed_q + CNT_W'(1);
            end else begin
              i_d = i_q + CNT_W'(1);
            end
            state_d = ST_READ;
          end
          default: begin
            if (flags.match) begin
              we        = 1'b1;
              used_d    = tail;
              removed_d = CNT_W'(1);
              state_d   = ST_FINISH;
            end else begin
              i_d     = i_q + CNT_W'(1);
              state_d = ST_READ;
            end
          end
        endcase
      end
      ST_FINISH: begin
        if (out_free) begin
          push = 1'b1;
          case (req_q)
            ostt_pkg::REQ_TICK: begin
              if (pend_valid_q) begin
                push_item.status     = ostt_pkg::ST_EXPIRED;
                push_item.expired_id = pend_id_wide[ostt_pkg::OUT_ID_W-1:0];
              end
            end
            ostt_pkg::REQ_STOP, ostt_pkg::REQ_REMOVE, ostt_pkg::REQ_RESET: begin
              push_item.status        = ostt_pkg::ST_REMOVED;
              push_item.removed_count = ostt_pkg::REMOVED_W'(removed_q);
            end
            default: begin
              push_item.status = ostt_pkg::ST_NOTHING;
            end
          endcase
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      i_q          <= '0;
      used_q       <= '0;
      removed_q    <= '0;
      rep_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      used_q       <= used_d;
      removed_q    <= removed_d;
      rep_q        <= rep_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Capture the request beat; id and count are reduced to the stored widths.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q    <= req_type_i;
      key_q    <= ID_BITS'(timer_id_i);
      cnt_q    <= COUNT_BITS'(tick_count_i);
      notify_q <= has_handler_i;
    end
    pend_id_q <= pend_id_d;
  end

  // Slot memory.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_cur_q  <= mem_q[i_q[IDX_W-1:0]];
      rd_tail_q <= mem_q[tail[IDX_W-1:0]];
    end
  end

  ostt_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .ready_i(out_ready_i),
    .free_o (out_free),
    .valid_o(out_valid_o),
    .item_o (out_item)
  );

  assign status_o        = out_item.status;
  assign expired_id_o    = out_item.expired_id;
  assign removed_count_o = out_item.removed_count;
  assign last_o          = out_item.last;

  `ASSERT_ALWAYS(a_used_bound, used_q <= CNT_W'(SLOTS), "entry count exceeds capacity")
  `ASSERT_IMPL(a_exec_in_range, state_q == ST_EXEC, i_q < used_q, "visit past last entry")
  `ASSERT_IMPL(a_push_room, push, out_free, "result beat pushed over a held beat")
  `ASSERT_IMPL(a_idle_no_pend, state_q == ST_IDLE, !pend_valid_q, "expiry left pending")

endmodule

[test/one_shot_timer_table_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the one-shot timer table: a directed request table, then
// random traffic, every result beat checked against a behavioral copy of the table or a typed value.
// Depends on ostt_pkg and the one_shot_timer_table RTL.

module one_shot_timer_table_tb;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned RAND_ITEMS   = 400;
  localparam int unsigned MAX_CYCLES   = 1_000_000;
  // Longest request is a full walk of the table, so let a little more pass at the end.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned HOLD_AFTER   = 150;  // result beats before the long receive hold
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PAUSE_AT     = 300;  // random request after which the sender drains
  localparam int unsigned MAX_REPORTED = 10;

  // Request codes the block ignores.
  localparam logic [ostt_pkg::REQ_W-1:0] REQ_UNDEF_LO = 3'd5;
  localparam logic [ostt_pkg::REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_ready_o;
  logic [ostt_pkg::REQ_W-1:0]      req_type_i    = ostt_pkg::REQ_TICK;
  logic [ostt_pkg::IN_ID_W-1:0]    timer_id_i    = '0;
  logic [ostt_pkg::IN_CNT_W-1:0]   tick_count_i  = '0;
  logic                            has_handler_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i   = 1'b0;
  logic [ostt_pkg::STATUS_W-1:0]   status_o;
  logic [ostt_pkg::OUT_ID_W-1:0]   expired_id_o;
  logic [ostt_pkg::REMOVED_W-1:0]  removed_count_o;
  logic                            last_o;

  // Hand-typed expectation that travels with the current request beat.
  logic                            typed_chk     = 1'b0;
  ostt_pkg::status_e               typed_status  = ostt_pkg::ST_NOTHING;
  logic [ostt_pkg::REMOVED_W-1:0]  typed_removed = '0;

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned beats_seen  = 0;
  int unsigned mismatches  = 0;

  ostt_pkg::out_item_t timer_results_due [$];

  one_shot_timer_table #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (ostt_pkg::IN_CNT_W),
    .ID_BITS    (ostt_pkg::IN_ID_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .timer_id_i      (timer_id_i),
    .tick_count_i    (tick_count_i),
    .has_handler_i   (has_handler_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .expired_id_o    (expired_id_o),
    .removed_count_o (removed_count_o),
    .last_o          (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Directed requests. Rows with typed set carry their single result beat by
  // hand; the rest are checked against the table model below. reps repeats a
  // row, which is how the table gets filled to capacity.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [ostt_pkg::REQ_W-1:0]     rq;
    logic [ostt_pkg::IN_ID_W-1:0]   id;
    logic [ostt_pkg::IN_CNT_W-1:0]  cnt;
    logic                           hh;
    int unsigned                    reps;
    bit                             typed;
    ostt_pkg::status_e              st;
    logic [ostt_pkg::REMOVED_W-1:0] rm;
  } stim_row_t;

  localparam int unsigned NUM_ROWS = 23;

  stim_row_t dir_rows [NUM_ROWS] = '{
    // empty table: tick, stop, remove and reset with nothing to act on
    '{ostt_pkg::REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1, 1'b1, ostt_pkg::ST_NOTHING, 5'd0},
    '{ostt_pkg::REQ_STOP, 16'h0000, 16'h0000, 1'b0, 1, 1'b1, ostt_pkg::ST_REMOVED, 5'd0},
    '{ostt_pkg::REQ_REMOVE, 16'hFFFF, 16'hFFFF, 1'b1, 1, 1'b1, ostt_pkg::ST_REMOVED, 5'd0},
    '{ostt_pkg::REQ_RESET, 16'h0000, 16'h0000, 1'b0, 1, 1'b1, ostt_pkg::ST_REMOVED, 5'd0},
    // zero count is refused
    '{ostt_pkg::REQ_ADD, 16'h00AA, 16'h0000, 1'b1, 1, 1'b1, ostt_pkg::ST_BADCOUNT, 5'd0},
    // extreme ids and counts, a duplicate id with and without notify
    '{ostt_pkg::REQ_ADD, 16'hFFFF, 16'h0001, 1'b1, 1, 1'b1, ostt_pkg::ST_ADDED, 5'd0},
    '{ostt_pkg::REQ_ADD, 16'h0000, 16'hFFFF, 1'b0, 1, 1'b1, ostt_pkg::ST_ADDED, 5'd0},
    '{ostt_pkg::REQ_ADD, 16'h1234, 16'h0002, 1'b1, 1, 1'b1, ostt_pkg::ST_ADDED, 5'd0},
    '{ostt_pkg::REQ_ADD, 16'h1234, 16'h0002, 1'b0, 1, 1'b1, ostt_pkg::ST_ADDED, 5'd0},
    // undefined request codes do nothing
    '{REQ_UNDEF_LO, 16'hFFFF, 16'hFFFF, 1'b1, 1, 1'b1, ostt_pkg::ST_NOTHING, 5'd0},
    '{REQ_UNDEF_HI, 16'h5A5A, 16'h0000, 1'b0, 1, 1'b1, ostt_pkg::ST_NOTHING, 5'd0},
    // expiries, with the tail entry swapped into the expired slot
    '{ostt_pkg::REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1, 1'b0, ostt_pkg::ST_NOTHING, 5'd0},
    '{ostt_pkg::REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1, 1'b0, ostt_pkg::ST_NOTHING, 5'd0},
    '{ostt_pkg::REQ_RESET, 16'h0000, 16'h0000, 1'b0, 1, 1'b0, ostt_pkg::ST_NOTHING, 5'd0},
    // fill to capacity, then full, then zero count on a full table
    '{ostt_pkg::REQ_ADD, 16'h0007, 16'h0001, 1'b1, 16, 1'b1, ostt_pkg::ST_ADDED, 5'd0},
    '{ostt_pkg::REQ_ADD, 16'h0008, 16'h0001, 1'b1, 1, 1'b1, ostt_pkg::ST_FULL, 5'd0},
    '{ostt_pkg::REQ_ADD, 16'h0008, 16'h0000, 1'b1, 1, 1'b1, ostt_pkg::ST_BADCOUNT, 5'd0},
    // sixteen expiries in one tick
    '{ostt_pkg::REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1, 1'b0, ostt_pkg::ST_NOTHING, 5'd0},
    // refill with one id: remove takes one, stop takes the rest
    '{ostt_pkg::REQ_ADD, 16'h0005, 16'h0003, 1'b0, 16, 1'b1, ostt_pkg::ST_ADDED, 5'd0},
    '{ostt_pkg::REQ_REMOVE, 16'h0005, 16'h0000, 1'b0, 1, 1'b1, ostt_pkg::ST_REMOVED, 5'd1},
    '{ostt_pkg::REQ_STOP, 16'h0005, 16'h0000, 1'b0, 1, 1'b1, ostt_pkg::ST_REMOVED, 5'd15},
    // expiry without notify stays silent
    '{ostt_pkg::REQ_ADD, 16'h00FF, 16'h0001, 1'b0, 1, 1'b1, ostt_pkg::ST_ADDED, 5'd0},
    '{ostt_pkg::REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1, 1'b0, ostt_pkg::ST_NOTHING, 5'd0}
  };

  // ---------------------------------------------------------------------------
  // Table model: same slot order and swap-on-remove as the block.
  // ---------------------------------------------------------------------------
  logic [ostt_pkg::IN_ID_W-1:0]  tbl_id  [SLOTS];
  logic [ostt_pkg::IN_CNT_W-1:0] tbl_cnt [SLOTS];
  logic                          tbl_ntf [SLOTS];
  int unsigned                   tbl_used = 0;

  function automatic ostt_pkg::out_item_t make_beat(ostt_pkg::status_e st,
                                                    logic [ostt_pkg::OUT_ID_W-1:0] id,
                                                    logic [ostt_pkg::REMOVED_W-1:0] rm,
                                                    logic lst);
    ostt_pkg::out_item_t b;
    b.status        = st;
    b.expired_id    = id;
    b.removed_count = rm;
    b.last          = lst;
    return b;
  endfunction

  // Drop one entry: move the tail entry into the freed slot.
  function automatic void vacate_slot(int unsigned pos);
    int unsigned tail;
    tail          = tbl_used - 1;
    tbl_id[pos]   = tbl_id[tail];
    tbl_cnt[pos]  = tbl_cnt[tail];
    tbl_ntf[pos]  = tbl_ntf[tail];
    tbl_used      = tail;
  endfunction

  // Apply one request to the model and return the result beats it causes.
  function automatic void advance_timer_table(input logic [ostt_pkg::REQ_W-1:0] rq,
                                              input logic [ostt_pkg::IN_ID_W-1:0] id,
                                              input logic [ostt_pkg::IN_CNT_W-1:0] cnt,
                                              input logic hh,
                                              output ostt_pkg::out_item_t beats [$]);
    int unsigned                   i;
    int unsigned                   dropped;
    logic [ostt_pkg::OUT_ID_W-1:0] fired [$];
    beats.delete();
    dropped = 0;
    i       = 0;
    case (rq)
      ostt_pkg::REQ_ADD: begin
        // Zero count is checked before fullness.
        if (cnt == '0) begin
          beats.push_back(make_beat(ostt_pkg::ST_BADCOUNT, '0, '0, 1'b1));
        end else if (tbl_used >= SLOTS) begin
          beats.push_back(make_beat(ostt_pkg::ST_FULL, '0, '0, 1'b1));
        end else begin
          tbl_id[tbl_used]  = id;
          tbl_cnt[tbl_used] = cnt;
          tbl_ntf[tbl_used] = hh;
          tbl_used++;
          beats.push_back(make_beat(ostt_pkg::ST_ADDED, '0, '0, 1'b1));
        end
      end
      ostt_pkg::REQ_STOP: begin
        // Revisit the slot after a drop: the swapped-in entry may match too.
        while (i < tbl_used) begin
          if (tbl_id[i] == id) begin
            vacate_slot(i);
            dropped++;
          end else begin
            i++;
          end
        end
        beats.push_back(make_beat(ostt_pkg::ST_REMOVED, '0,
                                  ostt_pkg::REMOVED_W'(dropped), 1'b1));
      end
      ostt_pkg::REQ_REMOVE: begin
        while (i < tbl_used && dropped == 0) begin
          if (tbl_id[i] == id) begin
            vacate_slot(i);
            dropped = 1;
          end else begin
            i++;
          end
        end
        beats.push_back(make_beat(ostt_pkg::ST_REMOVED, '0,
                                  ostt_pkg::REMOVED_W'(dropped), 1'b1));
      end
      ostt_pkg::REQ_TICK: begin
        while (i < tbl_used) begin
          tbl_cnt[i] = tbl_cnt[i] - 1'b1;
          if (tbl_cnt[i] == '0) begin
            // Past the report limit an expiry is still dropped, just not reported.
            if (tbl_ntf[i] && fired.size() < ostt_pkg::MAX_REPORTS) begin
              fired.push_back(tbl_id[i]);
            end
            vacate_slot(i);
          end else begin
            i++;
          end
        end
        if (fired.size() == 0) begin
          beats.push_back(make_beat(ostt_pkg::ST_NOTHING, '0, '0, 1'b1));
        end else begin
          foreach (fired[k]) begin
            beats.push_back(make_beat(ostt_pkg::ST_EXPIRED, fired[k], '0,
                                      k == fired.size() - 1));
          end
        end
      end
      ostt_pkg::REQ_RESET: begin
        beats.push_back(make_beat(ostt_pkg::ST_REMOVED, '0,
                                  ostt_pkg::REMOVED_W'(tbl_used), 1'b1));
        tbl_used = 0;
      end
      default: begin
        beats.push_back(make_beat(ostt_pkg::ST_NOTHING, '0, '0, 1'b1));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on each request beat, check on each result beat. Both
  // happen in one process so ordering within a time step cannot matter.
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(string what, ostt_pkg::out_item_t want,
                                        ostt_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTED) begin
      $display("%0t: %s: expected status %0d id %h removed %0d last %b",
               $time, what, want.status, want.expired_id, want.removed_count, want.last);
      $display("    got status %0d id %h removed %0d last %b",
               got.status, got.expired_id, got.removed_count, got.last);
    end
  endfunction

  always @(posedge clk_i) begin
    ostt_pkg::out_item_t new_beats [$];
    ostt_pkg::out_item_t got;
    ostt_pkg::out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_timer_table(req_type_i, timer_id_i, tick_count_i, has_handler_i, new_beats);
        // A typed row replaces the model's answer; the model still tracks the state.
        if (typed_chk) begin
          new_beats.delete();
          new_beats.push_back(make_beat(typed_status, '0, typed_removed, 1'b1));
        end
        foreach (new_beats[k]) timer_results_due.push_back(new_beats[k]);
      end
      if (out_valid_o && out_ready_i) begin
        beats_seen++;
        got.status        = status_o;
        got.expired_id    = expired_id_o;
        got.removed_count = removed_count_o;
        got.last          = last_o;
        if (timer_results_due.size() == 0) begin
          note_mismatch("result beat with nothing due", '0, got);
        end else begin
          want = timer_results_due.pop_front();
          if (got !== want) note_mismatch("result beat differs", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Mostly zero, sometimes a few cycles, now and then a long gap.
  function automatic int unsigned draw_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // Hold valid and payload until the request beat is taken. Valid is left
  // high so a back-to-back request needs only one assignment per edge.
  task automatic offer_request(logic [ostt_pkg::REQ_W-1:0] rq,
                               logic [ostt_pkg::IN_ID_W-1:0] id,
                               logic [ostt_pkg::IN_CNT_W-1:0] cnt, logic hh, bit typed,
                               ostt_pkg::status_e st, logic [ostt_pkg::REMOVED_W-1:0] rm);
    in_valid_i    <= 1'b1;
    req_type_i    <= rq;
    timer_id_i    <= id;
    tick_count_i  <= cnt;
    has_handler_i <= hh;
    typed_chk     <= typed;
    typed_status  <= st;
    typed_removed <= rm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Every third stretch of 40 requests runs with no gaps at all.
  task automatic idle_sender();
    int unsigned gap;
    gap = ((items_sent / 40) % 3 == 1) ? 0 : draw_idle();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every predicted result beat has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (timer_results_due.size() != 0);
  endtask

  // Mostly well-formed traffic over a small id pool, so stops and removes hit
  // real entries and ticks expire them; the rest is wide ids, long counts,
  // zero counts and undefined codes.
  function automatic void pick_random_request(output logic [ostt_pkg::REQ_W-1:0] rq,
                                              output logic [ostt_pkg::IN_ID_W-1:0] id,
                                              output logic [ostt_pkg::IN_CNT_W-1:0] cnt,
                                              output logic hh);
    int unsigned r;
    int unsigned c;
    r  = $urandom_range(0, 99);
    c  = $urandom_range(0, 19);
    id = ($urandom_range(0, 4) == 0) ? ostt_pkg::IN_ID_W'($urandom)
                                     : ostt_pkg::IN_ID_W'($urandom_range(0, 7));
    if (c < 15) cnt = ostt_pkg::IN_CNT_W'($urandom_range(1, 4));
    else if (c < 18) cnt = ostt_pkg::IN_CNT_W'($urandom_range(5, 40));
    else cnt = ostt_pkg::IN_CNT_W'($urandom);
    hh = 1'($urandom_range(0, 1));
    if (r < 42) rq = ostt_pkg::REQ_ADD;
    else if (r < 70) rq = ostt_pkg::REQ_TICK;
    else if (r < 78) rq = ostt_pkg::REQ_STOP;
    else if (r < 88) rq = ostt_pkg::REQ_REMOVE;
    else if (r < 91) rq = ostt_pkg::REQ_RESET;
    else if (r < 94) rq = ostt_pkg::REQ_W'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
    else begin
      rq  = ostt_pkg::REQ_ADD;
      cnt = '0;
    end
  endfunction

  initial begin : sender
    logic [ostt_pkg::REQ_W-1:0]    rq;
    logic [ostt_pkg::IN_ID_W-1:0]  id;
    logic [ostt_pkg::IN_CNT_W-1:0] cnt;
    logic                          hh;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      for (int unsigned k = 0; k < dir_rows[r].reps; k++) begin
        offer_request(dir_rows[r].rq, dir_rows[r].id, dir_rows[r].cnt, dir_rows[r].hh,
                      dir_rows[r].typed, dir_rows[r].st, dir_rows[r].rm);
        idle_sender();
      end
    end

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      pick_random_request(rq, id, cnt, hh);
      offer_request(rq, id, cnt, hh, 1'b0, ostt_pkg::ST_NOTHING, '0);
      // Pause once mid-run, and at the end, until the table has answered everything.
      if (n == PAUSE_AT || n == RAND_ITEMS - 1) drain_results();
      else idle_sender();
    end

    // Let the block settle; a stray beat here still counts as a mismatch.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, quiet stretches, and one long hold-off that
  // backs the block up into its request port while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall;
    bit          hold_done;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!hold_done && beats_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      stall = ((cycle_count / 500) % 4 == 2) ? 0 : draw_idle();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= MAX_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
